### design/adfp_pkg.sv
`timescale 1ns / 1ps

package adfp_pkg;

    // Largest number of fraction digits in a result.
    localparam int MAX_PLACES = 9;

    // Width of a power of ten up to 10^MAX_PLACES.
    localparam int SCALE_W = 30;
    localparam int INT_W   = 32;
    localparam int FRAC_W  = 30;
    localparam int CNT_W   = 4;
    localparam int PROD_W  = INT_W + SCALE_W;

    // Character classes handed from the front to the back.
    localparam logic [2:0] CLS_DIGIT = 3'd0;
    localparam logic [2:0] CLS_PLUS  = 3'd1;
    localparam logic [2:0] CLS_MINUS = 3'd2;
    localparam logic [2:0] CLS_DOT   = 3'd3;
    localparam logic [2:0] CLS_NUL   = 3'd4;
    localparam logic [2:0] CLS_OTHER = 3'd5;

    typedef struct packed {
        logic [2:0] cls;
        logic [3:0] digit;
    } char_entry_t;

    // A finished number on its way to scaling and range checking.
    typedef struct packed {
        logic              ok;
        logic              negative;
        logic [INT_W-1:0]  int_part;
        logic [FRAC_W-1:0] frac_part;
        logic [CNT_W-1:0]  frac_count;
        logic [CNT_W-1:0]  places;
    } number_t;

    function automatic logic [SCALE_W-1:0] pow10(input logic [CNT_W-1:0] n);
        logic [SCALE_W-1:0] r;
        case (n)
            4'd0:    r = 30'd1;
            4'd1:    r = 30'd10;
            4'd2:    r = 30'd100;
            4'd3:    r = 30'd1000;
            4'd4:    r = 30'd10000;
            4'd5:    r = 30'd100000;
            4'd6:    r = 30'd1000000;
            4'd7:    r = 30'd10000000;
            4'd8:    r = 30'd100000000;
            4'd9:    r = 30'd1000000000;
            default: r = 30'd0;
        endcase
        return r;
    endfunction

endpackage

### design/adfp_front.sv
`timescale 1ns / 1ps

module adfp_front
    import adfp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  character,
    input  logic        in_valid,
    output logic        in_stall,
    output logic        q_valid,
    output char_entry_t q_entry,
    input  logic        q_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

    char_entry_t            slot_reg [QUEUE_DEPTH];
    char_entry_t            cls_entry;
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CNT_QW-1:0]      count_reg, count_next;
    logic                   push;

    always_comb
    begin
        cls_entry.digit = character[3:0];
        if (character inside {[8'h30:8'h39]})
            cls_entry.cls = CLS_DIGIT;
        else if (character == 8'h2B)
            cls_entry.cls = CLS_PLUS;
        else if (character == 8'h2D)
            cls_entry.cls = CLS_MINUS;
        else if (character == 8'h2E)
            cls_entry.cls = CLS_DOT;
        else if (character == 8'h00)
            cls_entry.cls = CLS_NUL;
        else
            cls_entry.cls = CLS_OTHER;
    end

    assign in_stall = (count_reg == CNT_QW'(QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != '0);
    assign q_entry  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop)
            count_next = count_reg + 1'b1;
        else if (!push && q_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= cls_entry;
    end

endmodule

### design/adfp_back.sv
`timescale 1ns / 1ps

module adfp_back
    import adfp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  char_entry_t      q_entry,
    output logic             q_pop,
    input  logic             signed_allowed,
    input  logic [CNT_W-1:0] places,
    output logic             num_valid,
    output number_t          num,
    input  logic             num_ready
);

    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_INT   = 2'd1;
    localparam logic [1:0] PH_FRAC  = 2'd2;

    logic [1:0]        phase_reg, phase_next;
    logic              neg_reg, neg_next;
    logic              saw_reg, saw_next;
    logic              failed_reg, failed_next;
    logic [INT_W-1:0]  int_reg, int_next;
    logic [FRAC_W-1:0] frac_reg, frac_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    logic [INT_W+3:0]  int_wide;
    logic [FRAC_W+3:0] frac_wide;
    logic [CNT_W-1:0]  count_inc;
    logic              is_nul;
    logic              is_digit;

    assign is_nul    = (q_entry.cls == CLS_NUL);
    assign is_digit  = (q_entry.cls == CLS_DIGIT);
    assign num_valid = q_valid && is_nul;
    assign q_pop     = q_valid && (!is_nul || num_ready);

    assign int_wide  = ({4'd0, int_reg} << 3) + ({4'd0, int_reg} << 1)
                       + {{INT_W{1'b0}}, q_entry.digit};
    assign frac_wide = ({4'd0, frac_reg} << 3) + ({4'd0, frac_reg} << 1)
                       + {{FRAC_W{1'b0}}, q_entry.digit};
    assign count_inc = count_reg + 1'b1;

    always_comb
    begin
        num.ok         = !failed_reg && saw_reg && !(phase_reg == PH_FRAC && count_reg == '0)
                         && (count_reg <= places);
        num.negative   = neg_reg;
        num.int_part   = int_reg;
        num.frac_part  = frac_reg;
        num.frac_count = count_reg;
        num.places     = places;
    end

    always_comb
    begin
        phase_next  = phase_reg;
        neg_next    = neg_reg;
        saw_next    = saw_reg;
        failed_next = failed_reg;
        int_next    = int_reg;
        frac_next   = frac_reg;
        count_next  = count_reg;
        if (q_pop)
        begin
            if (is_nul)
            begin
                phase_next  = PH_START;
                neg_next    = 1'b0;
                saw_next    = 1'b0;
                failed_next = 1'b0;
                int_next    = '0;
                frac_next   = '0;
                count_next  = '0;
            end
            else if (!failed_reg)
            begin
                if (phase_reg == PH_START
                    && (q_entry.cls == CLS_PLUS || q_entry.cls == CLS_MINUS))
                begin
                    if (!signed_allowed)
                    begin
                        failed_next = 1'b1;
                    end
                    else
                    begin
                        neg_next   = (q_entry.cls == CLS_MINUS);
                        phase_next = PH_INT;
                    end
                end
                else if (phase_reg == PH_START || phase_reg == PH_INT)
                begin
                    phase_next = PH_INT;
                    if (is_digit)
                    begin
                        saw_next = 1'b1;
                        int_next = int_wide[INT_W-1:0];
                        // Anything above 32 bits ends the number as a failure.
                        if (int_wide[INT_W+3:INT_W] != 4'd0)
                            failed_next = 1'b1;
                    end
                    else if (q_entry.cls == CLS_DOT && saw_reg)
                    begin
                        phase_next = PH_FRAC;
                    end
                    else
                    begin
                        failed_next = 1'b1;
                    end
                end
                else if (phase_reg == PH_FRAC && is_digit)
                begin
                    count_next = count_inc;
                    if (count_inc > places)
                        failed_next = 1'b1;
                    else
                        frac_next = frac_wide[FRAC_W-1:0];
                end
                else
                begin
                    failed_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_START;
            neg_reg    <= 1'b0;
            saw_reg    <= 1'b0;
            failed_reg <= 1'b0;
            int_reg    <= '0;
            frac_reg   <= '0;
            count_reg  <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            neg_reg    <= neg_next;
            saw_reg    <= saw_next;
            failed_reg <= failed_next;
            int_reg    <= int_next;
            frac_reg   <= frac_next;
            count_reg  <= count_next;
        end
    end

endmodule

### design/adfp_finish.sv
`timescale 1ns / 1ps

module adfp_finish
    import adfp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               num_valid,
    input  number_t            num,
    output logic               num_ready,
    input  logic               signed_allowed,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               parse_ok,
    output logic signed [32:0] fixed_value
);

    logic                     s1_valid_reg;
    logic                     s1_ok_reg;
    logic                     s1_neg_reg;
    logic [PROD_W-1:0]        s1_prod_reg;
    logic [FRAC_W-1:0]        s1_frac_reg;
    logic                     out_valid_reg;
    logic                     parse_ok_reg;
    logic [32:0]              fixed_value_reg;

    logic                     ld_s1;
    logic                     ld_out;
    logic [PROD_W-1:0]        prod_calc;
    logic [FRAC_W+SCALE_W-1:0] frac_calc;
    logic [CNT_W-1:0]         pad_digits;
    logic [PROD_W:0]          mag;
    logic                     range_ok;
    logic [32:0]              value;

    assign ld_out    = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign num_ready = !s1_valid_reg || ld_out;
    assign ld_s1     = num_valid && num_ready;

    // Stage 1: scale the integer by 10^places and pad the fraction out to places digits.
    assign pad_digits = num.places - num.frac_count;
    assign prod_calc  = {{SCALE_W{1'b0}}, num.int_part} * {{INT_W{1'b0}}, pow10(num.places)};
    assign frac_calc  = {{SCALE_W{1'b0}}, num.frac_part} * {{FRAC_W{1'b0}}, pow10(pad_digits)};

    // Stage 2: add, range check and apply the sign.
    assign mag = {1'b0, s1_prod_reg} + {{(PROD_W + 1 - FRAC_W){1'b0}}, s1_frac_reg};

    always_comb
    begin
        if (signed_allowed)
            range_ok = s1_neg_reg ? (mag <= (PROD_W+1)'(64'h8000_0000))
                                  : (mag <= (PROD_W+1)'(64'h7FFF_FFFF));
        else
            range_ok = (mag <= (PROD_W+1)'(64'hFFFF_FFFF)) && (!s1_neg_reg || mag == '0);
        value = s1_neg_reg ? (33'd0 - mag[32:0]) : mag[32:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (num_ready)
                s1_valid_reg <= num_valid;
            if (!out_valid_reg || !out_stall)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_s1)
        begin
            s1_ok_reg   <= num.ok;
            s1_neg_reg  <= num.negative;
            s1_prod_reg <= prod_calc;
            s1_frac_reg <= frac_calc[FRAC_W-1:0];
        end
        if (ld_out)
        begin
            parse_ok_reg    <= s1_ok_reg && range_ok;
            fixed_value_reg <= (s1_ok_reg && range_ok) ? value : 33'd0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign parse_ok    = parse_ok_reg;
    assign fixed_value = fixed_value_reg;

endmodule

### design/ascii_decimal_fixed_point_parser_top.sv
`timescale 1ns / 1ps

// ASCII decimal to fixed-point parser. One character is taken per cycle unless
// in_stall is high; a NUL character closes the number and yields one result
// (parse_ok, fixed_value), while every other character yields none. The front
// classifies characters into a QUEUE_DEPTH-entry queue, the back steps the parse
// state one character per cycle (a NUL waits for num_ready), and a two-stage
// finish path (multiply into a pipeline register, then add and range check into
// the output register) delivers the result through both registers before out_valid
// rises; while out_stall stays low the sustained rate is one character per cycle.
// The user must write decimal_places (address 0) and signed_allowed (address 4)
// over the APB port only while no number is in flight; the block does not enforce it.

module ascii_decimal_fixed_point_parser_top
    import adfp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic [7:0]         character,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               parse_ok,
    output logic signed [32:0] fixed_value,
    output logic               out_valid,
    input  logic               out_stall
);

    localparam logic REG_PLACES = 1'b0;
    localparam logic REG_SIGNED = 1'b1;

    logic [CNT_W-1:0] places_reg;
    logic             signed_reg;
    logic [CNT_W-1:0] places_eff;
    logic             cfg_write;
    logic             reg_sel;

    char_entry_t      q_entry;
    logic             q_valid;
    logic             q_pop;
    number_t          num;
    logic             num_valid;
    logic             num_ready;

    assign pready    = 1'b1;
    assign reg_sel   = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            places_reg <= '0;
            signed_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            if (reg_sel == REG_PLACES)
                places_reg <= pwdata[CNT_W-1:0];
            else
                signed_reg <= pwdata[0];
        end
    end

    assign prdata = (reg_sel == REG_SIGNED) ? {31'd0, signed_reg}
                                            : {{(32 - CNT_W){1'b0}}, places_reg};

    assign places_eff = (places_reg > CNT_W'(MAX_PLACES)) ? CNT_W'(MAX_PLACES) : places_reg;

    adfp_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .character (character),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .q_pop     (q_pop)
    );

    adfp_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_entry        (q_entry),
        .q_pop          (q_pop),
        .signed_allowed (signed_reg),
        .places         (places_eff),
        .num_valid      (num_valid),
        .num            (num),
        .num_ready      (num_ready)
    );

    adfp_finish u_finish (
        .clk            (clk),
        .rst_n          (rst_n),
        .num_valid      (num_valid),
        .num            (num),
        .num_ready      (num_ready),
        .signed_allowed (signed_reg),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .parse_ok       (parse_ok),
        .fixed_value    (fixed_value)
    );

endmodule

### design/adfp_checker.sv
`timescale 1ns / 1ps

module adfp_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               pready,
    input logic               parse_ok,
    input logic signed [32:0] fixed_value,
    input logic               out_valid,
    input logic               out_stall
);

    // A stalled result stays put until its transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(parse_ok) && $stable(fixed_value))
        else $error("stalled result changed");

    // A failed parse carries a zero value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !parse_ok |-> fixed_value == 33'sd0)
        else $error("failed parse with nonzero value");

    // A negative result never goes below the int32 minimum.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && parse_ok && fixed_value[32] |-> fixed_value[31])
        else $error("negative result out of range");

    assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("configuration port not ready");

endmodule

bind ascii_decimal_fixed_point_parser_top adfp_checker u_adfp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .pready      (pready),
    .parse_ok    (parse_ok),
    .fixed_value (fixed_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall)
);

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import adfp_pkg::MAX_PLACES;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 300;
    localparam int TARGET_CHARS = 1350;
    localparam int N_ROWS       = 24;

    localparam logic [2:0] ADDR_PLACES = 3'd0;
    localparam logic [2:0] ADDR_SIGNED = 3'd4;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_PLUS  = "+";
    localparam logic [7:0] CH_MINUS = "-";
    localparam logic [7:0] CH_DOT   = ".";
    localparam logic [7:0] CH_ZERO  = "0";
    localparam logic [7:0] CH_NINE  = "9";

    localparam logic [3:0] EXT_PLACES [5] = '{4'd0, 4'd9, 4'd15, 4'd0, 4'd9};
    localparam bit         EXT_SIGNED [5] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

    typedef enum logic [1:0] {AT_START, IN_INT, IN_FRAC} number_phase_t;

    typedef struct packed {
        logic               ok;
        logic signed [32:0] value;
    } parse_result_t;

    typedef struct {
        logic [3:0] places;
        bit         sgn;
        string      text;
        bit         typed;
        bit         ok;
        longint     value;
    } directed_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic [7:0]         character = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               parse_ok;
    logic signed [32:0] fixed_value;
    logic               out_valid;
    logic               out_stall = 1'b0;

    ascii_decimal_fixed_point_parser_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .character   (character),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .parse_ok    (parse_ok),
        .fixed_value (fixed_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall)
    );

    always #1 clk = ~clk;

    // Parser state as the block should hold it, plus the register copies.
    number_phase_t num_phase;
    bit            num_negative;
    bit            num_has_digit;
    bit            num_failed;
    logic [63:0]   num_int;
    logic [63:0]   num_frac;
    int            num_frac_digits;
    logic [3:0]    cfg_places = 4'd0;
    bit            cfg_signed = 1'b1;

    parse_result_t awaited_numbers [$];
    parse_result_t oldest_number;
    int            failures = 0;
    int            sent_chars = 0;
    int            cycle_count = 0;
    bit            calm = 1'b0;
    bit            hold_go = 1'b0;
    bit            hold_rx = 1'b0;

    directed_row_t rows [N_ROWS] = '{
        '{4'd0,  1'b1, "",             1'b1, 1'b0, 64'sd0},
        '{4'd0,  1'b1, "0",            1'b1, 1'b1, 64'sd0},
        '{4'd0,  1'b1, "-0",           1'b1, 1'b1, 64'sd0},
        '{4'd0,  1'b1, "2147483647",   1'b1, 1'b1, 64'sd2147483647},
        '{4'd0,  1'b1, "-2147483648",  1'b1, 1'b1, -64'sd2147483648},
        '{4'd0,  1'b1, "2147483648",   1'b1, 1'b0, 64'sd0},
        '{4'd0,  1'b1, "+",            1'b1, 1'b0, 64'sd0},
        '{4'd0,  1'b1, "5-",           1'b1, 1'b0, 64'sd0},
        '{4'd0,  1'b1, "99999999999",  1'b1, 1'b0, 64'sd0},
        '{4'd0,  1'b1, "7a3",          1'b1, 1'b0, 64'sd0},
        '{4'd2,  1'b1, "1.",           1'b1, 1'b0, 64'sd0},
        '{4'd2,  1'b1, "1.2.3",        1'b1, 1'b0, 64'sd0},
        '{4'd2,  1'b1, ".5",           1'b1, 1'b0, 64'sd0},
        '{4'd2,  1'b1, "1.234",        1'b1, 1'b0, 64'sd0},
        '{4'd2,  1'b1, "1.25",         1'b0, 1'b0, 64'sd0},
        '{4'd2,  1'b1, "-3.5",         1'b0, 1'b0, 64'sd0},
        '{4'd0,  1'b0, "4294967295",   1'b1, 1'b1, 64'sd4294967295},
        '{4'd0,  1'b0, "4294967296",   1'b1, 1'b0, 64'sd0},
        '{4'd0,  1'b0, "+7",           1'b1, 1'b0, 64'sd0},
        '{4'd15, 1'b1, "1.123456789",  1'b0, 1'b0, 64'sd0},
        '{4'd9,  1'b1, "-2.147483648", 1'b0, 1'b0, 64'sd0},
        '{4'd9,  1'b1, "2.147483648",  1'b1, 1'b0, 64'sd0},
        '{4'd9,  1'b0, "4.294967295",  1'b0, 1'b0, 64'sd0},
        '{4'd15, 1'b0, "\3771",        1'b1, 1'b0, 64'sd0}
    };

    function automatic int places_in_use();
        return (cfg_places > MAX_PLACES) ? MAX_PLACES : int'(cfg_places);
    endfunction

    function automatic logic [63:0] ten_to(input int n);
        logic [63:0] r;
        int          i;
        r = 64'd1;
        for (i = 0; i < n; i++)
            r = r * 64'd10;
        return r;
    endfunction

    function automatic void clear_number();
        num_phase       = AT_START;
        num_negative    = 1'b0;
        num_has_digit   = 1'b0;
        num_failed      = 1'b0;
        num_int         = '0;
        num_frac        = '0;
        num_frac_digits = 0;
    endfunction

    function automatic void parse_char(input logic [7:0] c);
        bit is_digit;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        if (num_failed)
            return;
        if (num_phase == AT_START)
        begin
            if (c == CH_PLUS || c == CH_MINUS)
            begin
                if (!cfg_signed)
                begin
                    num_failed = 1'b1;
                    return;
                end
                num_negative = (c == CH_MINUS);
                num_phase    = IN_INT;
                return;
            end
            num_phase = IN_INT;
        end
        if (num_phase == IN_INT)
        begin
            if (is_digit)
            begin
                num_has_digit = 1'b1;
                num_int = num_int * 64'd10 + 64'(c - CH_ZERO);
                if (num_int > 64'hFFFF_FFFF)
                    num_failed = 1'b1;
            end
            else if (c == CH_DOT && num_has_digit)
            begin
                num_phase = IN_FRAC;
            end
            else
            begin
                num_failed = 1'b1;
            end
            return;
        end
        if (is_digit)
        begin
            num_frac_digits++;
            if (num_frac_digits > places_in_use())
            begin
                num_failed = 1'b1;
                return;
            end
            num_frac = num_frac * 64'd10 + 64'(c - CH_ZERO);
            return;
        end
        num_failed = 1'b1;
    endfunction

    // Scales the finished number, range-checks it and starts a new one.
    function automatic parse_result_t close_number();
        parse_result_t r;
        int            p;
        logic [63:0]   frac;
        logic [63:0]   mag;
        bit            ok;
        p = places_in_use();
        ok = !num_failed && num_has_digit && !(num_phase == IN_FRAC && num_frac_digits == 0)
             && num_frac_digits <= p;
        r.ok    = 1'b0;
        r.value = '0;
        if (ok)
        begin
            frac = num_frac * ten_to(p - num_frac_digits);
            mag  = num_int * ten_to(p) + frac;
            if (cfg_signed)
                ok = num_negative ? (mag <= 64'h8000_0000) : (mag <= 64'h7FFF_FFFF);
            else
                ok = (mag <= 64'hFFFF_FFFF) && (!num_negative || mag == 64'd0);
            if (ok)
            begin
                r.ok    = 1'b1;
                r.value = num_negative ? 33'(64'd0 - mag) : 33'(mag);
            end
        end
        clear_number();
        return r;
    endfunction

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (awaited_numbers.size() != 0) @(posedge clk);
    endtask

    task automatic apply_config(input logic [3:0] places, input bit sgn);
        drain_results();
        // Characters after a failure produce no result, so give the block time to settle.
        repeat (DRAIN_CYCLES) @(posedge clk);
        reg_write(ADDR_PLACES, {28'd0, places});
        reg_write(ADDR_SIGNED, {31'd0, sgn});
        cfg_places = places;
        cfg_signed = sgn;
    endtask

    task automatic send_char(input logic [7:0] c, input bit typed, input parse_result_t forced);
        parse_result_t r;
        while (!calm && $urandom_range(0, 99) < 13)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        character <= c;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent_chars++;
        if (c == CH_NUL)
        begin
            r = close_number();
            awaited_numbers.push_back(typed ? forced : r);
        end
        else
        begin
            parse_char(c);
        end
    endtask

    task automatic send_text(input string txt, input bit typed, input parse_result_t forced,
                             input int noise_pct);
        int i;
        for (i = 0; i < txt.len(); i++)
        begin
            if (noise_pct != 0 && $urandom_range(0, 99) < noise_pct)
                send_char(8'($urandom_range(1, 255)), 1'b0, forced);
            send_char(txt[i], 1'b0, forced);
        end
        send_char(CH_NUL, typed, forced);
    endtask

    // Mostly well-formed numbers, some aimed at the range limits, with some garbage mixed in.
    task automatic send_random_number();
        string         txt;
        string         frac_txt;
        int            kind;
        int            p;
        int            fd;
        int            i;
        logic [7:0]    nc;
        logic [63:0]   mag;
        parse_result_t unused;
        unused = '0;
        p    = places_in_use();
        kind = $urandom_range(0, 99);
        txt  = "";
        if (kind < 3)
        begin
            txt = "";
        end
        else if (kind < 9)
        begin
            for (i = $urandom_range(1, 6); i > 0; i--)
            begin
                nc  = 8'($urandom_range(1, 255));
                txt = {txt, $sformatf("%c", nc)};
            end
        end
        else
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: mag = 64'($urandom_range(0, 999));
                4, 5:       mag = 64'($urandom);
                6:          mag = {32'($urandom), 32'($urandom)};
                default:    mag = ($urandom_range(0, 1) ? 64'h8000_0000 : 64'h1_0000_0000)
                                  + 64'($urandom_range(0, 2)) - 64'd1;
            endcase
            fd  = (p == 0) ? 0 : $urandom_range(0, p);
            txt = $sformatf("%0d", mag / ten_to(p));
            if (fd > 0)
            begin
                frac_txt = $sformatf("%0d", mag % ten_to(p));
                while (frac_txt.len() < p)
                    frac_txt = {"0", frac_txt};
                txt = {txt, ".", frac_txt.substr(0, fd - 1)};
            end
            case ($urandom_range(0, 9))
                0:       txt = {"-", txt};
                1:       txt = {"+", txt};
                2:       if (cfg_signed) txt = {"-", txt};
                default: ;
            endcase
            case ($urandom_range(0, 29))
                0:       txt = {txt, "."};
                1:       txt = {txt, "7"};
                2:       txt = {".", txt};
                default: ;
            endcase
        end
        send_text(txt, 1'b0, unused, (kind < 20) ? 4 : 0);
    endtask

    always @(negedge clk)
        out_stall <= hold_rx || (!calm && $urandom_range(0, 99) < 13);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_numbers.size() == 0)
            begin
                $error("result with none awaited: parse_ok %0d fixed_value %0d",
                       parse_ok, fixed_value);
                failures++;
            end
            else
            begin
                oldest_number = awaited_numbers.pop_front();
                if (parse_ok !== oldest_number.ok)
                begin
                    $error("parse_ok: expected %0d, got %0d", oldest_number.ok, parse_ok);
                    failures++;
                end
                if (fixed_value !== oldest_number.value)
                begin
                    $error("fixed_value: expected %0d, got %0d",
                           oldest_number.value, fixed_value);
                    failures++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Output backs up for a long stretch while characters keep coming.
    initial
    begin
        wait (hold_go);
        hold_rx = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx = 1'b0;
    end

    initial
    begin
        int            i;
        int            n;
        int            phase_idx;
        parse_result_t forced;
        clear_number();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < N_ROWS; i++)
        begin
            if (rows[i].places != cfg_places || rows[i].sgn != cfg_signed)
                apply_config(rows[i].places, rows[i].sgn);
            forced.ok    = rows[i].ok;
            forced.value = rows[i].value[32:0];
            send_text(rows[i].text, rows[i].typed, forced, 0);
        end

        phase_idx = 0;
        while (phase_idx < 4 || sent_chars < TARGET_CHARS)
        begin
            if (phase_idx < 5)
                apply_config(EXT_PLACES[phase_idx], EXT_SIGNED[phase_idx]);
            else
                apply_config(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
            calm = (phase_idx == 3);
            n = $urandom_range(15, 40);
            for (i = 0; i < n; i++)
            begin
                if (phase_idx == 1 && i == 5)
                    hold_go = 1'b1;
                if (phase_idx == 2 && i == n / 2)
                    drain_results();
                send_random_number();
            end
            phase_idx++;
        end
        calm = 1'b0;

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### filelist.f
design/adfp_pkg.sv
design/adfp_front.sv
design/adfp_back.sv
design/adfp_finish.sv
design/ascii_decimal_fixed_point_parser_top.sv
design/adfp_checker.sv
tb/testbench.sv
